FILE: hdl/waste_container_controller_defines.svh
// Assertion macros for the waste container controller.
`ifndef WASTE_CONTAINER_CONTROLLER_DEFINES_SVH
`define WASTE_CONTAINER_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define WCC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wcc assertion failed");
// antecedent implies consequent in the next cycle
`define WCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wcc assertion failed");
`else
`define WCC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define WCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/wcc_pkg.sv
// Types and constants shared by the waste container controller.
package wcc_pkg;

    localparam int LIMIT_W       = 20;
    localparam int TIME_BITS_DEF = 20;
    localparam int REG_IDX_W     = 2;
    localparam int ADDR_W        = REG_IDX_W + 2;
    localparam int DATA_W        = 32;

    localparam logic [REG_IDX_W-1:0] REG_SLEEP   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SPILL   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RECEIVE = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_EMPTY   = 2'd3;

    localparam logic [LIMIT_W-1:0] SLEEP_LIMIT_RST   = 20'd10000;
    localparam logic [LIMIT_W-1:0] SPILL_LIMIT_RST   = 20'd5000;
    localparam logic [LIMIT_W-1:0] RECEIVE_LIMIT_RST = 20'd3000;
    localparam logic [LIMIT_W-1:0] EMPTY_LIMIT_RST   = 20'd3000;

    typedef enum logic [2:0] {
        MODE_READY   = 3'd0,
        MODE_WAITING = 3'd1,
        MODE_SLEEPING = 3'd2,
        MODE_SPILLING = 3'd3,
        MODE_FULL    = 3'd4,
        MODE_RECEIVING = 3'd5,
        MODE_EMPTYING = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_SIGNAL  = 3'd1,
        ACT_SPILL   = 3'd2,
        ACT_SLEEP   = 3'd3,
        ACT_STOP    = 3'd4,
        ACT_RECEIVE = 3'd5,
        ACT_EMPTY   = 3'd6
    } action_t;

    typedef struct packed {
        logic normal_mode;
        logic user_present;
        logic open_request;
        logic close_request;
        logic empty_request;
        logic full_flag;
    } tick_t;

endpackage

FILE: hdl/waste_container_controller.sv
// Waste container controller: mode state machine with elapsed-time counter.
//
//  channel   handshake            payload
//  -------   ---------            -------
//  in        in_valid/in_ready    normal_mode, user_present, open_request,
//                                 close_request, empty_request, full_flag
//  out       out_valid/out_ready  mode, action
//  cfg       APB write/read       paddr, pwdata, prdata (four 20-bit limits)
//
// One transaction per cycle sustained while out_ready is high; in passes
// through the input register, then the state update into the result register.
// rst_n clears the mode to ready, the counter to zero and limits to defaults.
// A full result register with out_ready low stalls the state update; the
// input register still takes one more transaction if it is empty.
`include "waste_container_controller_defines.svh"

module waste_container_controller #(
    parameter int TIME_BITS = wcc_pkg::TIME_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wcc_pkg::ADDR_W-1:0]  paddr,
    input  logic [wcc_pkg::DATA_W-1:0]  pwdata,
    output logic [wcc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        normal_mode,
    input  logic                        user_present,
    input  logic                        open_request,
    input  logic                        close_request,
    input  logic                        empty_request,
    input  logic                        full_flag,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  mode,
    output logic [2:0]                  action
);
    import wcc_pkg::*;

    localparam int CMP_W = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic [LIMIT_W-1:0]   sleep_limit_reg, spill_limit_reg;
    logic [LIMIT_W-1:0]   receive_limit_reg, empty_limit_reg;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    logic                 in_valid_reg;
    tick_t                tick_reg;
    logic                 adv;

    mode_t                mode_reg, mode_next;
    action_t              act_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next, elapsed_inc;
    logic [CMP_W-1:0]     elapsed_cmp;
    logic                 sleep_to, spill_to, receive_to, empty_to;

    logic                 out_valid_reg;
    mode_t                out_mode_reg;
    action_t              out_action_reg;

    // configuration
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sleep_limit_reg   <= SLEEP_LIMIT_RST;
            spill_limit_reg   <= SPILL_LIMIT_RST;
            receive_limit_reg <= RECEIVE_LIMIT_RST;
            empty_limit_reg   <= EMPTY_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_SLEEP:   sleep_limit_reg   <= pwdata[LIMIT_W-1:0];
                REG_SPILL:   spill_limit_reg   <= pwdata[LIMIT_W-1:0];
                REG_RECEIVE: receive_limit_reg <= pwdata[LIMIT_W-1:0];
                REG_EMPTY:   empty_limit_reg   <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_SLEEP:   prdata = DATA_W'(sleep_limit_reg);
            REG_SPILL:   prdata = DATA_W'(spill_limit_reg);
            REG_RECEIVE: prdata = DATA_W'(receive_limit_reg);
            REG_EMPTY:   prdata = DATA_W'(empty_limit_reg);
            default:     prdata = '0;
        endcase
    end

    // input register
    assign adv      = in_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~in_valid_reg | adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid & in_ready)
            tick_reg <= '{normal_mode, user_present, open_request,
                          close_request, empty_request, full_flag};
    end

    // counter and timeouts
    assign elapsed_inc = (elapsed_reg != TIME_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign elapsed_cmp = CMP_W'(elapsed_inc);
    assign sleep_to    = elapsed_cmp > CMP_W'(sleep_limit_reg);
    assign spill_to    = elapsed_cmp > CMP_W'(spill_limit_reg);
    assign receive_to  = elapsed_cmp > CMP_W'(receive_limit_reg);
    assign empty_to    = elapsed_cmp > CMP_W'(empty_limit_reg);

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        if (tick_reg.normal_mode)
        begin
            case (mode_reg)
                MODE_READY:
                    if (!tick_reg.user_present)
                        mode_next = MODE_WAITING;
                    else if (tick_reg.open_request)
                        mode_next = MODE_SPILLING;
                MODE_WAITING:
                    if (tick_reg.user_present)
                        mode_next = MODE_READY;
                    else if (sleep_to)
                        mode_next = MODE_SLEEPING;
                MODE_SLEEPING:
                    if (tick_reg.user_present)
                        mode_next = MODE_READY;
                MODE_SPILLING:
                    if (tick_reg.full_flag)
                        mode_next = MODE_FULL;
                    else if (tick_reg.close_request || spill_to)
                        mode_next = MODE_RECEIVING;
                MODE_FULL:
                    if (tick_reg.empty_request && !tick_reg.full_flag)
                        mode_next = MODE_EMPTYING;
                MODE_RECEIVING:
                    if (receive_to)
                        mode_next = MODE_READY;
                MODE_EMPTYING:
                    if (empty_to)
                        mode_next = MODE_READY;
                default: ;
            endcase
        end
    end

    // action
    always_comb
    begin
        act_next = ACT_NONE;
        if (tick_reg.normal_mode)
        begin
            case (mode_reg)
                MODE_READY:
                    if (tick_reg.user_present && tick_reg.open_request)
                        act_next = ACT_SPILL;
                MODE_WAITING:
                    if (tick_reg.user_present)
                        act_next = ACT_SIGNAL;
                    else if (sleep_to)
                        act_next = ACT_SLEEP;
                MODE_SLEEPING:
                    if (tick_reg.user_present)
                        act_next = ACT_SIGNAL;
                MODE_SPILLING:
                    if (tick_reg.full_flag)
                        act_next = ACT_STOP;
                    else if (tick_reg.close_request || spill_to)
                        act_next = ACT_RECEIVE;
                MODE_FULL:
                    if (tick_reg.empty_request && !tick_reg.full_flag)
                        act_next = ACT_EMPTY;
                MODE_RECEIVING:
                    if (receive_to)
                        act_next = ACT_SIGNAL;
                MODE_EMPTYING:
                    if (empty_to)
                        act_next = ACT_SIGNAL;
                default: ;
            endcase
        end
    end

    assign elapsed_next = (mode_next != mode_reg) ? '0 : elapsed_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_READY;
            elapsed_reg <= '0;
        end
        else if (adv)
        begin
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= adv | (out_valid_reg & ~out_ready);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_mode_reg   <= mode_next;
            out_action_reg <= act_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign mode      = out_mode_reg;
    assign action    = out_action_reg;

    `WCC_ASSERT_NEXT(a_frozen_mode, clk, rst_n, adv && !tick_reg.normal_mode, $stable(mode_reg))
    `WCC_ASSERT_NEXT(a_restart_on_change, clk, rst_n,
                     adv && (mode_next != mode_reg), elapsed_reg == '0)
    `WCC_ASSERT_NEXT(a_hold_when_stalled, clk, rst_n,
                     !adv, $stable(mode_reg) && $stable(elapsed_reg))
    `WCC_ASSERT_SAME(a_action_means_change, clk, rst_n,
                     adv && (act_next != ACT_NONE), mode_next != mode_reg)

endmodule
